// File: hdl/cpa_pkg.sv
// Shared types and constants of the cross power pixel accumulator.
// Used by the pixel store, the multiply-accumulate datapath and the top level.
// No dependencies.
package cpa_pkg;

    localparam int PIXELS    = 4096;
    localparam int PIX_BITS  = 12;
    localparam int SMP_BITS  = 24;
    localparam int ACC_BITS  = 64;
    localparam int PWR_BITS  = 63;
    localparam int PROD_BITS = 2 * SMP_BITS;
    localparam int TERM_BITS = PROD_BITS + 2;

    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic signed [SMP_BITS-1:0] obs_im;
        logic signed [SMP_BITS-1:0] obs_re;
        logic signed [SMP_BITS-1:0] pred_im;
        logic signed [SMP_BITS-1:0] pred_re;
    } sample_t;

    typedef struct packed {
        logic                       sat;
        logic        [PWR_BITS-1:0] power;
        logic signed [ACC_BITS-1:0] cross_im;
        logic signed [ACC_BITS-1:0] cross_re;
    } entry_t;

    typedef struct packed {
        logic                we;
        logic [PIX_BITS-1:0] addr;
        entry_t              data;
    } mem_wr_t;

endpackage

// File: hdl/cpa_store.sv
// Per-pixel sum store: one synchronous memory with one write and one read port.
// Read data is registered and appears in the cycle after the read request.
// Depends on cpa_pkg.
module cpa_store
(
    input  logic                          clk,
    input  cpa_pkg::mem_wr_t              wr,
    input  logic                          rd_en,
    input  logic [cpa_pkg::PIX_BITS-1:0]  rd_addr,
    output cpa_pkg::entry_t               rd_data
);

    cpa_pkg::entry_t mem [cpa_pkg::PIXELS];
    cpa_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/cpa_mac.sv
// Multiply-accumulate datapath: registered products, registered terms, and a
// saturating update of one pixel entry. Depends on cpa_pkg.
module cpa_mac
(
    input  logic             clk,
    input  cpa_pkg::sample_t smp,
    input  cpa_pkg::entry_t  old_entry,
    output cpa_pkg::entry_t  new_entry
);

    localparam int AB = cpa_pkg::ACC_BITS;
    localparam int TB = cpa_pkg::TERM_BITS;
    localparam int PB = cpa_pkg::PROD_BITS;

    logic signed [PB-1:0] rr_reg, ii_reg, ri_reg, ir_reg, pp_reg, qq_reg;
    logic signed [TB-1:0] re_term_reg, im_term_reg, pw_term_reg;
    logic [AB:0] re_res, im_res, pw_res;

    function automatic logic [AB:0] sat_add(input logic signed [AB-1:0] acc,
                                            input logic signed [TB-1:0] term);
        logic signed [AB:0] s;
        s = {acc[AB-1], acc} + {{(AB + 1 - TB){term[TB-1]}}, term};
        if (s[AB] != s[AB-1])
        begin
            if (s[AB])
            begin
                return {1'b1, 1'b1, {(AB - 1){1'b0}}};
            end
            return {1'b1, 1'b0, {(AB - 1){1'b1}}};
        end
        return {1'b0, s[AB-1:0]};
    endfunction

    always_ff @(posedge clk)
    begin
        rr_reg <= smp.obs_re * smp.pred_re;
        ii_reg <= smp.obs_im * smp.pred_im;
        ri_reg <= smp.obs_re * smp.pred_im;
        ir_reg <= smp.obs_im * smp.pred_re;
        pp_reg <= smp.pred_re * smp.pred_re;
        qq_reg <= smp.pred_im * smp.pred_im;
    end

    always_ff @(posedge clk)
    begin
        re_term_reg <= TB'(rr_reg) + TB'(ii_reg);
        im_term_reg <= TB'(ri_reg) - TB'(ir_reg);
        pw_term_reg <= TB'(pp_reg) + TB'(qq_reg);
    end

    always_comb
    begin
        re_res = sat_add(old_entry.cross_re, re_term_reg);
        im_res = sat_add(old_entry.cross_im, im_term_reg);
        pw_res = sat_add({1'b0, old_entry.power}, pw_term_reg);
        new_entry.cross_re = re_res[AB-1:0];
        new_entry.cross_im = im_res[AB-1:0];
        new_entry.power    = pw_res[cpa_pkg::PWR_BITS-1:0];
        new_entry.sat      = old_entry.sat | re_res[AB] | im_res[AB] | pw_res[AB];
    end

endmodule

// File: hdl/cross_power_pixel_accumulator.sv
// Top level of the cross power pixel accumulator: control sequencer, store and datapath.
// Depends on cpa_pkg, cpa_store and cpa_mac.
//
// The block keeps, for each of 4096 pixels, saturating 64-bit sums of conj(O)*P and a
// 63-bit sum of |P|^2 in one synchronous memory, and handles one item at a time. An
// accumulate item passes through accept, read and multiply, term sum, and saturate and
// write back; a clear item through accept and write; a read item through accept, read
// and output, where it waits while the previous result still sits unconsumed in the
// output register; unknown opcodes are dropped at accept. These steps follow from the
// read-modify-write over the single memory read port with its registered read data and
// the two-stage multiplier pipeline. After reset the block zeroes the memory, one pixel
// per cycle, and holds s_tready low until that pass is complete.
module cross_power_pixel_accumulator
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pixel_index[11:0], pred_re[35:12], pred_im[59:36], obs_re[83:60], obs_im[107:84]
    input  logic [111:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_pixel[11:0], cross_re_sum[75:12], cross_im_sum[139:76], power_sum[202:140]
    output logic [207:0] m_tdata,
    // saturated[0]
    output logic         m_tuser
);

    localparam int PB = cpa_pkg::PIX_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TERM,
        ST_WRITE,
        ST_OUT,
        ST_CLEAR
    } state_t;

    state_t                   state_reg, state_next;
    logic                     clearing_reg, clearing_next;
    logic [PB-1:0]            clr_cnt_reg, clr_cnt_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [207:0]             m_tdata_reg, m_tdata_next;
    logic                     m_tuser_reg, m_tuser_next;

    logic [1:0]               op_reg;
    logic [PB-1:0]            pix_reg;
    cpa_pkg::sample_t         smp_reg;

    cpa_pkg::mem_wr_t         wr;
    logic                     rd_en;
    cpa_pkg::entry_t          rd_data;
    cpa_pkg::entry_t          new_entry;
    logic                     in_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !clearing_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg          <= s_tuser;
            pix_reg         <= s_tdata[11:0];
            smp_reg.pred_re <= s_tdata[35:12];
            smp_reg.pred_im <= s_tdata[59:36];
            smp_reg.obs_re  <= s_tdata[83:60];
            smp_reg.obs_im  <= s_tdata[107:84];
        end
    end

    cpa_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (pix_reg),
        .rd_data (rd_data)
    );

    cpa_mac u_mac
    (
        .clk       (clk),
        .smp       (smp_reg),
        .old_entry (rd_data),
        .new_entry (new_entry)
    );

    always_comb
    begin
        state_next    = state_reg;
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        rd_en         = 1'b0;
        wr.we         = 1'b0;
        wr.addr       = pix_reg;
        wr.data       = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (clearing_reg)
        begin
            wr.we        = 1'b1;
            wr.addr      = clr_cnt_reg;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == PB'(cpa_pkg::PIXELS - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_tuser)
                        cpa_pkg::OP_ACC, cpa_pkg::OP_READ: state_next = ST_READ;
                        cpa_pkg::OP_CLEAR:                 state_next = ST_CLEAR;
                        default:                           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                rd_en = 1'b1;
                state_next = (op_reg == cpa_pkg::OP_READ) ? ST_OUT : ST_TERM;
            end
            ST_TERM:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                wr.we      = 1'b1;
                wr.data    = new_entry;
                state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, rd_data.power, rd_data.cross_im,
                                     rd_data.cross_re, pix_reg};
                    m_tuser_next  = rd_data.sat;
                    state_next    = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                wr.we      = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_tready)
        else $error("Input accepted during the clearing pass.");

    a_busy_during_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_tuser == cpa_pkg::OP_ACC)) |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("Accumulate item overlapped by a new item.");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !m_tvalid_reg) |=> m_tvalid)
        else $error("Read result was not loaded into the output register.");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> (clearing_reg || state_reg == ST_WRITE || state_reg == ST_CLEAR))
        else $error("Unexpected memory write.");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for cross_power_pixel_accumulator, with its own per-pixel sum model.
// Depends on cpa_pkg and the accumulator RTL. Random item streams are checked against predictions.
module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [cpa_pkg::SMP_BITS-1:0] S_MAX =
        {1'b0, {(cpa_pkg::SMP_BITS-1){1'b1}}};
    localparam logic signed [cpa_pkg::SMP_BITS-1:0] S_MIN =
        {1'b1, {(cpa_pkg::SMP_BITS-1){1'b0}}};
    localparam logic signed [67:0] ACC_HI = {5'b0, {(cpa_pkg::ACC_BITS-1){1'b1}}};
    localparam logic signed [67:0] ACC_LO = -ACC_HI - 68'sd1;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]                          opcode;
        logic [cpa_pkg::PIX_BITS-1:0]        pixel;
        logic signed [cpa_pkg::SMP_BITS-1:0] pred_re;
        logic signed [cpa_pkg::SMP_BITS-1:0] pred_im;
        logic signed [cpa_pkg::SMP_BITS-1:0] obs_re;
        logic signed [cpa_pkg::SMP_BITS-1:0] obs_im;
    } pixel_op_t;

    typedef struct {
        logic [cpa_pkg::PIX_BITS-1:0]        pixel;
        logic signed [cpa_pkg::ACC_BITS-1:0] cross_re;
        logic signed [cpa_pkg::ACC_BITS-1:0] cross_im;
        logic [cpa_pkg::PWR_BITS-1:0]        power;
        logic                                sat;
    } pixel_sums_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;
    logic         m_tuser;

    logic signed [cpa_pkg::ACC_BITS-1:0] cross_re_mem [cpa_pkg::PIXELS];
    logic signed [cpa_pkg::ACC_BITS-1:0] cross_im_mem [cpa_pkg::PIXELS];
    logic signed [cpa_pkg::ACC_BITS-1:0] power_mem [cpa_pkg::PIXELS];
    logic                                sat_mem [cpa_pkg::PIXELS];

    pixel_op_t   op_queue [$];
    pixel_sums_t sums_expected [$];
    pixel_op_t   cur_op;
    logic        fast_mode = 1'b0;
    int          errors = 0;
    int          ops_accepted = 0;
    int          sums_read = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;

    cross_power_pixel_accumulator uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic clamp_add(inout logic signed [cpa_pkg::ACC_BITS-1:0] acc,
                             input logic signed [66:0] term, inout logic hit);
        logic signed [67:0] total;
        total = acc + term;
        if (total > ACC_HI)
        begin
            acc = ACC_HI[cpa_pkg::ACC_BITS-1:0];
            hit = 1'b1;
        end
        else if (total < ACC_LO)
        begin
            acc = ACC_LO[cpa_pkg::ACC_BITS-1:0];
            hit = 1'b1;
        end
        else
        begin
            acc = total[cpa_pkg::ACC_BITS-1:0];
        end
    endtask

    task automatic apply_to_pixel_sums(input pixel_op_t op);
        logic signed [66:0]                  re_term;
        logic signed [66:0]                  im_term;
        logic signed [66:0]                  pw_term;
        logic signed [cpa_pkg::ACC_BITS-1:0] acc_re;
        logic signed [cpa_pkg::ACC_BITS-1:0] acc_im;
        logic signed [cpa_pkg::ACC_BITS-1:0] acc_pw;
        logic                                hit;
        pixel_sums_t                         sums;
        case (op.opcode)
            cpa_pkg::OP_ACC:
            begin
                re_term = op.obs_re * op.pred_re + op.obs_im * op.pred_im;
                im_term = op.obs_re * op.pred_im - op.obs_im * op.pred_re;
                pw_term = op.pred_re * op.pred_re + op.pred_im * op.pred_im;
                acc_re = cross_re_mem[op.pixel];
                acc_im = cross_im_mem[op.pixel];
                acc_pw = power_mem[op.pixel];
                hit = 1'b0;
                clamp_add(acc_re, re_term, hit);
                clamp_add(acc_im, im_term, hit);
                clamp_add(acc_pw, pw_term, hit);
                cross_re_mem[op.pixel] = acc_re;
                cross_im_mem[op.pixel] = acc_im;
                power_mem[op.pixel] = acc_pw;
                if (hit)
                begin
                    sat_mem[op.pixel] = 1'b1;
                end
            end
            cpa_pkg::OP_READ:
            begin
                sums.pixel = op.pixel;
                sums.cross_re = cross_re_mem[op.pixel];
                sums.cross_im = cross_im_mem[op.pixel];
                sums.power = power_mem[op.pixel][cpa_pkg::PWR_BITS-1:0];
                sums.sat = sat_mem[op.pixel];
                sums_expected.push_back(sums);
            end
            cpa_pkg::OP_CLEAR:
            begin
                cross_re_mem[op.pixel] = '0;
                cross_im_mem[op.pixel] = '0;
                power_mem[op.pixel] = '0;
                sat_mem[op.pixel] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_sums();
        pixel_sums_t want;
        pixel_sums_t got;
        got.pixel = m_tdata[11:0];
        got.cross_re = m_tdata[75:12];
        got.cross_im = m_tdata[139:76];
        got.power = m_tdata[202:140];
        got.sat = m_tuser;
        sums_read++;
        if (sums_expected.size() == 0)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("ERROR: unexpected result for pixel %0d", got.pixel);
            end
        end
        else
        begin
            want = sums_expected.pop_front();
            if (got.pixel !== want.pixel || got.cross_re !== want.cross_re
                || got.cross_im !== want.cross_im || got.power !== want.power
                || got.sat !== want.sat)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: expected pix=%0d re=%0d im=%0d pw=%0d sat=%0b",
                             want.pixel, want.cross_re, want.cross_im, want.power, want.sat);
                    $display("       actual   pix=%0d re=%0d im=%0d pw=%0d sat=%0b",
                             got.pixel, got.cross_re, got.cross_im, got.power, got.sat);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_to_pixel_sums(cur_op);
                ops_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (op_queue.size() > 0 && (fast_mode || $urandom_range(99) >= 33))
                begin
                    cur_op = op_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, cur_op.obs_im, cur_op.obs_re, cur_op.pred_im,
                                cur_op.pred_re, cur_op.pixel};
                    s_tuser <= cur_op.opcode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_sums();
                if (sums_read == 30 || sums_read == 250)
                begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= fast_mode || ($urandom_range(99) >= 33);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic add_op(input logic [1:0] opcode, input int pixel,
                          input logic signed [cpa_pkg::SMP_BITS-1:0] pr,
                          input logic signed [cpa_pkg::SMP_BITS-1:0] pi,
                          input logic signed [cpa_pkg::SMP_BITS-1:0] orr,
                          input logic signed [cpa_pkg::SMP_BITS-1:0] oi);
        pixel_op_t op;
        op.opcode = opcode;
        op.pixel = pixel[cpa_pkg::PIX_BITS-1:0];
        op.pred_re = pr;
        op.pred_im = pi;
        op.obs_re = orr;
        op.obs_im = oi;
        op_queue.push_back(op);
    endtask

    function automatic logic signed [cpa_pkg::SMP_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0: return S_MAX;
            1: return S_MIN;
            2: return cpa_pkg::SMP_BITS'($signed($urandom_range(16)) - 8);
            default: return cpa_pkg::SMP_BITS'($urandom);
        endcase
    endfunction

    function automatic int rand_pixel();
        int pick;
        pick = $urandom_range(9);
        if (pick < 7)
        begin
            return $urandom_range(15);
        end
        else if (pick == 7)
        begin
            return cpa_pkg::PIXELS - 16 + $urandom_range(15);
        end
        return $urandom_range(cpa_pkg::PIXELS - 1);
    endfunction

    task automatic add_random_op();
        int pick;
        logic [1:0] opcode;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            opcode = cpa_pkg::OP_ACC;
        end
        else if (pick < 83)
        begin
            opcode = cpa_pkg::OP_READ;
        end
        else if (pick < 93)
        begin
            opcode = cpa_pkg::OP_CLEAR;
        end
        else
        begin
            opcode = OP_UNUSED;
        end
        add_op(opcode, rand_pixel(), rand_sample(), rand_sample(), rand_sample(), rand_sample());
    endtask

    task automatic drain();
        do
        begin
            @(posedge clk);
        end
        while (op_queue.size() != 0 || s_tvalid || sums_expected.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int pix;
        int count;
        for (int i = 0; i < cpa_pkg::PIXELS; i++)
        begin
            cross_re_mem[i] = '0;
            cross_im_mem[i] = '0;
            power_mem[i] = '0;
            sat_mem[i] = 1'b0;
        end
        @(posedge rst_n);

        add_op(cpa_pkg::OP_ACC, 0, S_MAX, S_MAX, S_MAX, S_MAX);
        add_op(cpa_pkg::OP_ACC, 0, S_MIN, S_MIN, S_MIN, S_MIN);
        add_op(cpa_pkg::OP_READ, 0, 0, 0, 0, 0);
        add_op(cpa_pkg::OP_ACC, cpa_pkg::PIXELS - 1, S_MAX, S_MIN, S_MIN, S_MAX);
        add_op(cpa_pkg::OP_ACC, cpa_pkg::PIXELS - 1, S_MIN, S_MAX, S_MAX, S_MIN);
        add_op(cpa_pkg::OP_READ, cpa_pkg::PIXELS - 1, S_MAX, S_MAX, S_MAX, S_MAX);
        add_op(cpa_pkg::OP_READ, 1, 0, 0, 0, 0);
        add_op(OP_UNUSED, 0, S_MAX, S_MIN, S_MAX, S_MIN);
        add_op(cpa_pkg::OP_READ, 0, 0, 0, 0, 0);
        add_op(cpa_pkg::OP_CLEAR, 0, S_MAX, S_MAX, S_MAX, S_MAX);
        add_op(cpa_pkg::OP_READ, 0, 0, 0, 0, 0);
        add_op(cpa_pkg::OP_CLEAR, cpa_pkg::PIXELS - 1, 0, 0, 0, 0);
        add_op(cpa_pkg::OP_ACC, cpa_pkg::PIXELS - 1, -24'sd3, 24'sd5, 24'sd7, -24'sd11);
        add_op(cpa_pkg::OP_READ, cpa_pkg::PIXELS - 1, 0, 0, 0, 0);
        add_op(cpa_pkg::OP_ACC, 5, 24'sd1, -24'sd1, S_MAX, S_MIN);
        add_op(cpa_pkg::OP_ACC, 5, S_MIN, 24'sd2, -24'sd2, S_MAX);
        add_op(cpa_pkg::OP_ACC, 5, 24'sd0, 24'sd0, S_MIN, S_MIN);
        add_op(cpa_pkg::OP_READ, 5, 0, 0, 0, 0);
        add_op(cpa_pkg::OP_CLEAR, 2730, 0, 0, 0, 0);
        add_op(cpa_pkg::OP_READ, 2730, 0, 0, 0, 0);
        add_op(cpa_pkg::OP_ACC, 1365, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        add_op(cpa_pkg::OP_READ, 1365, 0, 0, 0, 0);
        drain();

        // Hit one pixel back to back with full-scale samples, then read it and clear it.
        fast_mode = 1'b1;
        for (int i = 0; i < 200; i++)
        begin
            add_op(cpa_pkg::OP_ACC, 7, S_MIN, S_MIN, S_MIN, S_MIN);
            if (i == 99)
            begin
                add_op(cpa_pkg::OP_READ, 7, 0, 0, 0, 0);
            end
        end
        add_op(cpa_pkg::OP_READ, 7, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++)
        begin
            add_op(cpa_pkg::OP_ACC, 7, S_MIN, S_MIN, S_MAX, S_MAX);
        end
        add_op(cpa_pkg::OP_READ, 7, 0, 0, 0, 0);
        add_op(cpa_pkg::OP_CLEAR, 7, 0, 0, 0, 0);
        add_op(cpa_pkg::OP_READ, 7, 0, 0, 0, 0);
        drain();
        fast_mode = 1'b0;

        for (int chunk = 0; chunk < 4; chunk++)
        begin
            count = 0;
            while (count < 450)
            begin
                if ($urandom_range(9) < 6)
                begin
                    pix = rand_pixel();
                    if ($urandom_range(1) == 0)
                    begin
                        add_op(cpa_pkg::OP_CLEAR, pix, rand_sample(), rand_sample(), 0, 0);
                        count++;
                    end
                    for (int k = $urandom_range(1, 8); k > 0; k--)
                    begin
                        add_op(cpa_pkg::OP_ACC, pix, rand_sample(), rand_sample(),
                               rand_sample(), rand_sample());
                        count++;
                    end
                    add_op(cpa_pkg::OP_READ, pix, 0, 0, 0, 0);
                    count++;
                end
                else
                begin
                    add_random_op();
                    count++;
                end
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (sums_expected.size() != 0)
        begin
            $display("ERROR: %0d results never arrived", sums_expected.size());
            errors += sums_expected.size();
        end
        $display("Sent %0d items and checked %0d pixel readbacks, with a back-to-back run",
                 ops_accepted, sums_read);
        $display("on one pixel, long output stalls and %0d mismatches.", errors);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: cross_power_pixel_accumulator.f
hdl/cpa_pkg.sv
hdl/cpa_store.sv
hdl/cpa_mac.sv
hdl/cross_power_pixel_accumulator.sv
verif/tb_top.sv
